FILE: design/wpg2d_pkg.sv
// ----------------------------------------------------------------------------
// wpg2d_pkg: shared types and constants of the wrapped phase gradient block
// Field widths, configuration register codes, reset values and the wrapped
// phase difference.
// ----------------------------------------------------------------------------
`default_nettype none

package wpg2d_pkg;

  localparam int PHASE_W        = 16;
  localparam int PHASE_BITS     = 16;
  localparam int SUM_W          = PHASE_BITS + 1;
  localparam int SCALE_W        = 16;
  localparam int GRAD_W         = 24;
  localparam int SHIFT_EDGE     = 8;
  localparam int SHIFT_INT      = 9;

  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_DIM_W      = 11;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int FRAME_WIDTH_RST  = 1024;
  localparam int FRAME_HEIGHT_RST = 1024;
  localparam logic [SCALE_W-1:0] X_SCALE_RST = SCALE_W'(256);
  localparam logic [SCALE_W-1:0] Y_SCALE_RST = SCALE_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_X_SCALE,
    CFG_Y_SCALE
  } cfg_index_e;

  typedef enum logic [1:0] {
    RES_MAIN,
    RES_EXTRA,
    RES_FINAL
  } res_e;

  function automatic logic signed [PHASE_BITS-1:0] wrap_diff(
    input logic [PHASE_BITS-1:0] hi,
    input logic [PHASE_BITS-1:0] lo
  );
    return signed'(hi - lo);
  endfunction

endpackage

`default_nettype wire

FILE: design/wpg2d_ram.sv
// ----------------------------------------------------------------------------
// wpg2d_ram: generic single write, single read memory
// One write port and one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module wpg2d_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/wpg2d_scale.sv
// ----------------------------------------------------------------------------
// wpg2d_scale: gradient scaling unit
// Multiplies a wrapped difference sum by a Q8.8 scale, rounds half up at the
// edge or interior shift, and saturates to the gradient width.
// ----------------------------------------------------------------------------
`default_nettype none

module wpg2d_scale
  import wpg2d_pkg::*;
(
  input  logic signed [SUM_W-1:0]   sum_i,
  input  logic        [SCALE_W-1:0] scale_i,
  input  logic                      interior_i,
  output logic signed [GRAD_W-1:0]  grad_o
);

  localparam int PROD_W = SUM_W + SCALE_W + 1;
  localparam int RND_W  = PROD_W + 1;

  localparam logic signed [RND_W-1:0] HALF_EDGE = RND_W'(2 ** (SHIFT_EDGE - 1));
  localparam logic signed [RND_W-1:0] HALF_INT  = RND_W'(2 ** (SHIFT_INT - 1));
  localparam logic signed [RND_W-1:0] GRAD_HI   = RND_W'(2 ** (GRAD_W - 1) - 1);
  localparam logic signed [RND_W-1:0] GRAD_LO   = RND_W'(-(2 ** (GRAD_W - 1)));

  logic signed [SCALE_W:0]  scale_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W-1:0]  shifted;

  assign scale_s = signed'({1'b0, scale_i});
  assign prod    = PROD_W'(sum_i) * PROD_W'(scale_s);
  assign rnd     = RND_W'(prod) + (interior_i ? HALF_INT : HALF_EDGE);
  assign shifted = interior_i ? (rnd >>> SHIFT_INT) : (rnd >>> SHIFT_EDGE);

  always_comb begin
    priority if (shifted > GRAD_HI) begin
      grad_o = GRAD_HI[GRAD_W-1:0];
    end else if (shifted < GRAD_LO) begin
      grad_o = GRAD_LO[GRAD_W-1:0];
    end else begin
      grad_o = shifted[GRAD_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/wrapped_phase_gradient_2d_core.sv
// ----------------------------------------------------------------------------
// wrapped_phase_gradient_2d_core: wrapped phase central difference gradient
// Raster pixel stream in, per pixel column, row and scaled x/y gradients out.
// ----------------------------------------------------------------------------
// The completing pixel loads the capture register, then the result register.
// Throughput: one pixel per cycle unless out_stall_i holds the output; a
// last-row pixel past column 0 yields two results and the final pixel three,
// one per cycle unless out_stall_i holds the output, stalling the input.
// Reset: counters to frame start, registers to defaults; the two line
// buffers are not cleared and hold valid data once the rows are written.
// ----------------------------------------------------------------------------
`default_nettype none

module wrapped_phase_gradient_2d_core
  import wpg2d_pkg::*;
#(
  parameter  int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter  int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int CW         = $clog2(MAX_WIDTH),
  localparam int RW         = $clog2(MAX_HEIGHT)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [PHASE_W-1:0] phase_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [CW-1:0]            column_o,
  output logic [RW-1:0]            row_o,
  output logic signed [GRAD_W-1:0] grad_x_o,
  output logic signed [GRAD_W-1:0] grad_y_o,
  output logic                     frame_last_o
);

  localparam int WW   = CW + 1;
  localparam int HW   = RW + 1;
  localparam int WRST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int HRST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  // configuration
  logic [WW-1:0]      w_q, w_d;
  logic [HW-1:0]      h_q, h_d;
  logic [SCALE_W-1:0] xs_q, xs_d, ys_q, ys_d;
  logic [31:0]        cfg_dim;
  cfg_index_e         cfg_idx;

  // position
  logic [CW-1:0] col_q, col_d, c_cur;
  logic [RW-1:0] row_q, row_d, r_cur;
  logic [HW-1:0] r_pre, r_inc;
  logic [WW-1:0] c_inc, c_inc2, c_wrap2;
  logic          row_end, last_row;
  logic          in_accept;

  // line buffers and window
  logic [CW-1:0]         lp_raddr, lp2_raddr;
  logic [PHASE_BITS-1:0] lp_rd, lp2_rd;
  logic [PHASE_BITS-1:0] p_val, d_val;
  logic [PHASE_BITS-1:0] a_q, b_q, p1_q, p2_q, byp_data_q;
  logic                  byp_q;

  // wrapped differences
  logic signed [PHASE_BITS-1:0] wd_db, wd_ba, wd_pb, wd_be, wd_pp1, wd_p1p2, wd_p1a;
  logic signed [SUM_W-1:0]      sx_d [3];
  logic signed [SUM_W-1:0]      sy_d [3];
  logic [2:0]                   xi_d, yi_d;
  logic                         has_main, has_extra, has_final;
  res_e                         cnt_d;

  // capture stage
  logic                    s_valid_q, s_valid_d;
  res_e                    s_idx_q, s_idx_d, s_cnt_q, s_cnt_d;
  logic signed [SUM_W-1:0] s_sx_q [3];
  logic signed [SUM_W-1:0] s_sy_q [3];
  logic [2:0]              s_xi_q, s_yi_q;
  logic [CW-1:0]           s_c_q;
  logic [RW-1:0]           s_r_q;

  // emission
  logic signed [SUM_W-1:0]  sel_sx, sel_sy;
  logic                     sel_xi, sel_yi;
  logic [CW-1:0]            sel_col;
  logic [RW-1:0]            sel_row;
  logic                     sel_last;
  logic signed [GRAD_W-1:0] gx, gy;
  logic                     out_load, s_done;

  // result register
  logic                     out_valid_q, out_valid_d;
  logic [CW-1:0]            out_col_q;
  logic [RW-1:0]            out_row_q;
  logic signed [GRAD_W-1:0] out_gx_q, out_gy_q;
  logic                     out_last_q;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cfg_index_e'(cfg_index_i);
  assign cfg_dim     = 32'(cfg_data_i[CFG_DIM_W-1:0]);

  always_comb begin
    w_d  = w_q;
    h_d  = h_q;
    xs_d = xs_q;
    ys_d = ys_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx)
        CFG_FRAME_WIDTH: begin
          priority if (cfg_dim < 32'd2) begin
            w_d = WW'(2);
          end else if (cfg_dim > 32'(MAX_WIDTH)) begin
            w_d = WW'(MAX_WIDTH);
          end else begin
            w_d = WW'(cfg_dim);
          end
        end
        CFG_FRAME_HEIGHT: begin
          priority if (cfg_dim < 32'd2) begin
            h_d = HW'(2);
          end else if (cfg_dim > 32'(MAX_HEIGHT)) begin
            h_d = HW'(MAX_HEIGHT);
          end else begin
            h_d = HW'(cfg_dim);
          end
        end
        CFG_X_SCALE: xs_d = cfg_data_i[SCALE_W-1:0];
        CFG_Y_SCALE: ys_d = cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // position counters
  // --------------------------------------------------------------------------
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    if ({1'b0, col_q} >= w_q) begin
      c_cur = '0;
      r_pre = {1'b0, row_q} + HW'(1);
    end else begin
      c_cur = col_q;
      r_pre = {1'b0, row_q};
    end
    r_cur    = (r_pre >= h_q) ? '0 : r_pre[RW-1:0];
    c_inc    = {1'b0, c_cur} + WW'(1);
    c_inc2   = {1'b0, c_cur} + WW'(2);
    c_wrap2  = c_inc2 - w_q;
    r_inc    = {1'b0, r_cur} + HW'(1);
    row_end  = c_inc >= w_q;
    last_row = r_inc >= h_q;

    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = last_row ? '0 : r_inc[RW-1:0];
      end else begin
        col_d = c_inc[CW-1:0];
        row_d = r_cur;
      end
    end
  end

  // --------------------------------------------------------------------------
  // line buffers: prefetch two columns ahead on the previous row,
  // one column ahead on the row before it
  // --------------------------------------------------------------------------
  assign lp_raddr  = (c_inc2 >= w_q) ? c_wrap2[CW-1:0] : c_inc2[CW-1:0];
  assign lp2_raddr = row_end ? '0 : c_inc[CW-1:0];
  assign p_val     = phase_i[PHASE_BITS-1:0];
  assign d_val     = byp_q ? byp_data_q : lp_rd;

  wpg2d_ram #(
    .WIDTH (PHASE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_prev (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (c_cur),
    .wdata_i (p_val),
    .re_i    (in_accept),
    .raddr_i (lp_raddr),
    .rdata_o (lp_rd)
  );

  wpg2d_ram #(
    .WIDTH (PHASE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_prev2 (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (c_cur),
    .wdata_i (b_q),
    .re_i    (in_accept),
    .raddr_i (lp2_raddr),
    .rdata_o (lp2_rd)
  );

  // --------------------------------------------------------------------------
  // difference sums for the up to three results of this word
  // --------------------------------------------------------------------------
  assign wd_db   = wrap_diff(d_val, b_q);
  assign wd_ba   = wrap_diff(b_q, a_q);
  assign wd_pb   = wrap_diff(p_val, b_q);
  assign wd_be   = wrap_diff(b_q, lp2_rd);
  assign wd_pp1  = wrap_diff(p_val, p1_q);
  assign wd_p1p2 = wrap_diff(p1_q, p2_q);
  assign wd_p1a  = wrap_diff(p1_q, a_q);

  always_comb begin
    priority if (c_cur == '0) begin
      sx_d[0] = SUM_W'(wd_db);
      xi_d[0] = 1'b0;
    end else if (row_end) begin
      sx_d[0] = SUM_W'(wd_ba);
      xi_d[0] = 1'b0;
    end else begin
      sx_d[0] = SUM_W'(wd_db) + SUM_W'(wd_ba);
      xi_d[0] = 1'b1;
    end

    if (r_cur == RW'(1)) begin
      sy_d[0] = SUM_W'(wd_pb);
      yi_d[0] = 1'b0;
    end else begin
      sy_d[0] = SUM_W'(wd_pb) + SUM_W'(wd_be);
      yi_d[0] = 1'b1;
    end

    if (c_cur == CW'(1)) begin
      sx_d[1] = SUM_W'(wd_pp1);
      xi_d[1] = 1'b0;
    end else begin
      sx_d[1] = SUM_W'(wd_pp1) + SUM_W'(wd_p1p2);
      xi_d[1] = 1'b1;
    end
    sy_d[1] = SUM_W'(wd_p1a);
    yi_d[1] = 1'b0;

    sx_d[2] = SUM_W'(wd_pp1);
    xi_d[2] = 1'b0;
    sy_d[2] = SUM_W'(wd_pb);
    yi_d[2] = 1'b0;
  end

  assign has_main  = r_cur != '0;
  assign has_extra = last_row && (c_cur != '0);
  assign has_final = has_extra && row_end;

  always_comb begin
    priority if (has_final) begin
      cnt_d = RES_FINAL;
    end else if (has_extra) begin
      cnt_d = RES_EXTRA;
    end else begin
      cnt_d = RES_MAIN;
    end
  end

  // --------------------------------------------------------------------------
  // capture stage control
  // --------------------------------------------------------------------------
  assign out_load   = s_valid_q && (!out_valid_q || !out_stall_i);
  assign s_done     = out_load && (s_idx_q == s_cnt_q);
  assign in_stall_o = s_valid_q && !s_done;

  always_comb begin
    s_valid_d = s_valid_q;
    s_idx_d   = s_idx_q;
    s_cnt_d   = s_cnt_q;
    priority if (in_accept) begin
      s_valid_d = has_main;
      s_idx_d   = RES_MAIN;
      s_cnt_d   = cnt_d;
    end else if (s_done) begin
      s_valid_d = 1'b0;
    end else if (out_load) begin
      s_idx_d = res_e'(2'(s_idx_q) + 2'd1);
    end
  end

  // --------------------------------------------------------------------------
  // result selection and scaling
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (s_idx_q)
      RES_EXTRA: begin
        sel_sx  = s_sx_q[1];
        sel_sy  = s_sy_q[1];
        sel_xi  = s_xi_q[1];
        sel_yi  = s_yi_q[1];
        sel_col = s_c_q - CW'(1);
        sel_row = s_r_q;
      end
      RES_FINAL: begin
        sel_sx  = s_sx_q[2];
        sel_sy  = s_sy_q[2];
        sel_xi  = s_xi_q[2];
        sel_yi  = s_yi_q[2];
        sel_col = s_c_q;
        sel_row = s_r_q;
      end
      default: begin
        sel_sx  = s_sx_q[0];
        sel_sy  = s_sy_q[0];
        sel_xi  = s_xi_q[0];
        sel_yi  = s_yi_q[0];
        sel_col = s_c_q;
        sel_row = s_r_q - RW'(1);
      end
    endcase
  end

  assign sel_last = s_idx_q == RES_FINAL;

  wpg2d_scale u_scale_x (
    .sum_i      (sel_sx),
    .scale_i    (xs_q),
    .interior_i (sel_xi),
    .grad_o     (gx)
  );

  wpg2d_scale u_scale_y (
    .sum_i      (sel_sy),
    .scale_i    (ys_q),
    .interior_i (sel_yi),
    .grad_o     (gy)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= WW'(WRST);
      h_q         <= HW'(HRST);
      xs_q        <= X_SCALE_RST;
      ys_q        <= Y_SCALE_RST;
      col_q       <= '0;
      row_q       <= '0;
      byp_q       <= 1'b0;
      s_valid_q   <= 1'b0;
      s_idx_q     <= RES_MAIN;
      s_cnt_q     <= RES_MAIN;
      out_valid_q <= 1'b0;
    end else begin
      w_q         <= w_d;
      h_q         <= h_d;
      xs_q        <= xs_d;
      ys_q        <= ys_d;
      col_q       <= col_d;
      row_q       <= row_d;
      if (in_accept) begin
        byp_q <= lp_raddr == c_cur;
      end
      s_valid_q   <= s_valid_d;
      s_idx_q     <= s_idx_d;
      s_cnt_q     <= s_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_q        <= b_q;
      b_q        <= d_val;
      p1_q       <= p_val;
      p2_q       <= p1_q;
      byp_data_q <= p_val;
      s_sx_q     <= sx_d;
      s_sy_q     <= sy_d;
      s_xi_q     <= xi_d;
      s_yi_q     <= yi_d;
      s_c_q      <= c_cur;
      s_r_q      <= r_cur;
    end
    if (out_load) begin
      out_col_q  <= sel_col;
      out_row_q  <= sel_row;
      out_gx_q   <= gx;
      out_gy_q   <= gy;
      out_last_q <= sel_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign column_o     = out_col_q;
  assign row_o        = out_row_q;
  assign grad_x_o     = out_gx_q;
  assign grad_y_o     = out_gy_q;
  assign frame_last_o = out_last_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb_wrapped_phase_gradient_2d_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wrapped_phase_gradient_2d_core: self-checking bench for the gradient core
// Streams whole frames of wrapped phase pixels through the core under random
// handshake gaps and stalls. A local model of the line buffers and counters
// predicts every column/row/gradient word, and each output word is checked
// in order against it. Frame size and scales change between frames only.
// ----------------------------------------------------------------------------

module tb_wrapped_phase_gradient_2d_core;
  import wpg2d_pkg::*;

  localparam longint GRAD_MAX = 2 ** (GRAD_W - 1) - 1;
  localparam longint GRAD_MIN = -(2 ** (GRAD_W - 1));

  typedef struct packed {
    logic [9:0]               column;
    logic [9:0]               row;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     frame_last;
  } grad_result_t;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  cfg_index_e               cfg_index  = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]    cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic signed [PHASE_W-1:0] phase     = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [9:0]               column;
  logic [9:0]               row;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic                     frame_last;

  wrapped_phase_gradient_2d_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .phase_i      (phase),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .column_o     (column),
    .row_o        (row),
    .grad_x_o     (grad_x),
    .grad_y_o     (grad_y),
    .frame_last_o (frame_last)
  );

  always #6 clk_i = ~clk_i;

  logic [15:0]  line_prev  [MAX_WIDTH_DEF];
  logic [15:0]  line_prev2 [MAX_WIDTH_DEF];
  logic [10:0]  width_reg  = CFG_DIM_W'(FRAME_WIDTH_RST);
  logic [10:0]  height_reg = CFG_DIM_W'(FRAME_HEIGHT_RST);
  logic [15:0]  xscale_reg = X_SCALE_RST;
  logic [15:0]  yscale_reg = Y_SCALE_RST;
  int unsigned  col_cnt    = 0;
  int unsigned  row_cnt    = 0;
  logic [15:0]  left_px    = '0;

  grad_result_t grad_q [$];
  logic [15:0]  pixel_q [$];
  int unsigned  tx_wait    = 0;
  int unsigned  rx_wait    = 0;
  bit           tx_burst   = 1'b0;
  bit           rx_burst   = 1'b0;
  int unsigned  mismatches = 0;

  function automatic int unsigned dim_eff(input logic [10:0] v, input int unsigned max_v);
    if (v < 2) return 2;
    if (v > max_v) return max_v;
    return v;
  endfunction

  function automatic longint wrap16(input logic [15:0] a, input logic [15:0] b);
    logic signed [15:0] d;
    d = a - b;
    return d;
  endfunction

  function automatic logic signed [GRAD_W-1:0] scale_sat(input longint sum,
                                                         input logic [15:0] scale,
                                                         input int k);
    longint s;
    longint v;
    s = scale;
    v = (sum * s + (longint'(1) << (k - 1))) >>> k;
    if (v > GRAD_MAX) v = GRAD_MAX;
    else if (v < GRAD_MIN) v = GRAD_MIN;
    return v[GRAD_W-1:0];
  endfunction

  function automatic logic signed [GRAD_W-1:0] grad3(input logic [15:0] lo,
                                                     input logic [15:0] mid,
                                                     input logic [15:0] hi,
                                                     input int unsigned pos,
                                                     input int unsigned n,
                                                     input logic [15:0] scale);
    if (pos == 0) return scale_sat(wrap16(hi, mid), scale, SHIFT_EDGE);
    if (pos + 1 >= n) return scale_sat(wrap16(mid, lo), scale, SHIFT_EDGE);
    return scale_sat(wrap16(hi, mid) + wrap16(mid, lo), scale, SHIFT_INT);
  endfunction

  task automatic predict_gradients(input logic [15:0] p);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    int unsigned  q;
    logic [15:0]  a;
    logic [15:0]  b;
    logic [15:0]  d;
    logic [15:0]  e;
    logic [15:0]  lo;
    grad_result_t res;
    w = dim_eff(width_reg, MAX_WIDTH_DEF);
    h = dim_eff(height_reg, MAX_HEIGHT_DEF);
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    c = col_cnt;
    r = row_cnt;
    a = left_px;
    b = line_prev[c];
    d = (c + 1 < w) ? line_prev[c + 1] : '0;
    e = line_prev2[c];
    if (r >= 1) begin
      res.column     = c[9:0];
      res.row        = 10'(r - 1);
      res.grad_x     = grad3(a, b, d, c, w, xscale_reg);
      res.grad_y     = (r == 1) ? scale_sat(wrap16(p, b), yscale_reg, SHIFT_EDGE)
                                : scale_sat(wrap16(p, b) + wrap16(b, e), yscale_reg, SHIFT_INT);
      res.frame_last = 1'b0;
      grad_q.push_back(res);
    end
    line_prev2[c] = b;
    line_prev[c]  = p;
    left_px       = b;
    if (r + 1 == h && c >= 1) begin
      q  = c - 1;
      lo = (q >= 1) ? line_prev[q - 1] : '0;
      res.column     = q[9:0];
      res.row        = r[9:0];
      res.grad_x     = grad3(lo, line_prev[q], p, q, w, xscale_reg);
      res.grad_y     = scale_sat(wrap16(line_prev[q], line_prev2[q]), yscale_reg, SHIFT_EDGE);
      res.frame_last = 1'b0;
      grad_q.push_back(res);
      if (c + 1 == w) begin
        res.column     = c[9:0];
        res.row        = r[9:0];
        res.grad_x     = scale_sat(wrap16(p, line_prev[q]), xscale_reg, SHIFT_EDGE);
        res.grad_y     = scale_sat(wrap16(p, b), yscale_reg, SHIFT_EDGE);
        res.frame_last = 1'b1;
        grad_q.push_back(res);
      end
    end
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
      left_px = '0;
    end
  endtask

  function automatic int unsigned gap_draw(input bit burst);
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [15:0] scale_draw();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(64, 1024));
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      phase    <= '0;
      tx_wait  <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) predict_gradients(phase);
      if (tx_wait != 0) begin
        in_valid <= 1'b0;
        tx_wait  <= tx_wait - 1;
      end else if (pixel_q.size() != 0) begin
        in_valid <= 1'b1;
        phase    <= pixel_q.pop_front();
        tx_wait  <= gap_draw(tx_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    grad_result_t got;
    grad_result_t want;
    int unsigned  nxt;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else begin
      nxt = rx_wait;
      if (out_valid && !out_stall) begin
        got = {column, row, grad_x, grad_y, frame_last};
        if (grad_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: col %0d row %0d gx %0d gy %0d last %0b",
                     got.column, got.row, got.grad_x, got.grad_y, got.frame_last);
        end else begin
          want = grad_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: expected col %0d row %0d gx %0d gy %0d last %0b, %s",
                       want.column, want.row, want.grad_x, want.grad_y, want.frame_last,
                       $sformatf("got col %0d row %0d gx %0d gy %0d last %0b",
                                 got.column, got.row, got.grad_x, got.grad_y,
                                 got.frame_last));
          end
        end
        nxt = gap_draw(rx_burst);
      end else if (nxt != 0) begin
        nxt--;
      end
      rx_wait   <= nxt;
      out_stall <= (nxt != 0);
    end
  end

  task automatic cfg_write(input cfg_index_e idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_FRAME_WIDTH:  width_reg  = data[10:0];
      CFG_FRAME_HEIGHT: height_reg = data[10:0];
      CFG_X_SCALE:      xscale_reg = data;
      CFG_Y_SCALE:      yscale_reg = data;
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [15:0] w, input logic [15:0] h,
                           input logic [15:0] xs, input logic [15:0] ys);
    cfg_write(CFG_FRAME_WIDTH, w);
    cfg_write(CFG_FRAME_HEIGHT, h);
    cfg_write(CFG_X_SCALE, xs);
    cfg_write(CFG_Y_SCALE, ys);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || in_valid || grad_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_frame(input int kind, input bit pause);
    int unsigned w;
    int unsigned h;
    logic [15:0] base;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] v;
    w    = dim_eff(width_reg, MAX_WIDTH_DEF);
    h    = dim_eff(height_reg, MAX_HEIGHT_DEF);
    base = 16'($urandom);
    sx   = $urandom_range(0, 1) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
    sy   = $urandom_range(0, 1) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        case (kind)
          0:       v = 16'($urandom);
          1:       v = base + 16'(c * sx) + 16'(r * sy) + 16'($urandom_range(0, 14)) - 16'd7;
          default: v = {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 2)) - 16'd1;
        endcase
        pixel_q.push_back(v);
        // hold until every outstanding word is back
        if (pause && r == h / 2 && c == w / 2) drain();
      end
    end
  endtask

  initial begin
    int unsigned items;
    int unsigned frames;
    int unsigned w;
    int          kind;
    foreach (line_prev[i]) begin
      line_prev[i]  = '0;
      line_prev2[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_frame(16'd2, 16'd2, X_SCALE_RST, Y_SCALE_RST);
    pixel_q = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    drain();
    set_frame(16'd3, 16'd3, 16'hFFFF, 16'hFFFF);
    pixel_q = '{16'h0000, 16'h8000, 16'h0000,
                16'h8000, 16'h0000, 16'h8000,
                16'h7FFF, 16'h8000, 16'h7FFF};
    drain();
    set_frame(16'h0000, 16'hF801, 16'h0000, 16'h0000);
    pixel_q = '{16'h1234, 16'h8000, 16'h7FFF, 16'h0001};
    drain();

    items  = 0;
    frames = 0;
    while (items < 470) begin
      w        = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      set_frame($urandom_range(0, 1) ? {5'($urandom), 11'(w)} : 16'(w),
                16'($urandom_range(2, 8)), scale_draw(), scale_draw());
      kind = $urandom_range(0, 5);
      send_frame((kind < 3) ? 1 : (kind < 5) ? 0 : 2,
                 frames == 2 || $urandom_range(0, 9) == 0);
      drain();
      items += dim_eff(width_reg, MAX_WIDTH_DEF) * dim_eff(height_reg, MAX_HEIGHT_DEF);
      frames++;
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
